[design/aligned_bump_page_allocator_unit_assert.svh]
// assertion macros for the aligned bump page allocator
// used by aligned_bump_page_allocator_unit, no other dependencies
`ifndef ALIGNED_BUMP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define ALIGNED_BUMP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ABPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ABPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/abpa_pkg.sv]
// shared widths and codes of the aligned bump page allocator
// no dependencies
package abpa_pkg;

  localparam int PAGE_W = 36;
  localparam int CNT_W  = 10;
  localparam int VM_W   = 4;
  localparam int STAT_W = 2;

  // remainder loop retires one dividend bit per cycle
  localparam int DIV_STEPS = PAGE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NULL      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EXHAUSTED = 2'd2;

endpackage

[design/aligned_bump_page_allocator_unit.sv]
// aligned bump page allocator, one pool per virtual machine
// depends on abpa_pkg and aligned_bump_page_allocator_unit_assert.svh
//
//  channel | role   | handshake            | fields
//  --------+--------+----------------------+--------------------------------------
//  request | input  | in_valid / in_ready  | func, vm_id, page_count, start_page
//  result  | output | out_valid / out_ready| page_number, status
//
// a set, a zero count or a rejected request goes from the check step straight to emit
// an allocation runs check, 36 steps of the shared restoring
//   remainder unit (one page-number bit a cycle), pad, finish and emit
// reset clears the per-vm valid bits at once, so there is no clearing pass
// results sit in an output register; a new request is taken while one waits,
//   and the emit step holds until that register is free
`include "aligned_bump_page_allocator_unit_assert.svh"

module aligned_bump_page_allocator_unit
  import abpa_pkg::*;
#(
  parameter int VM_COUNT    = 16,
  parameter int POOL_PAGES  = 4096,
  parameter int MAX_REQUEST = 1023
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [VM_W-1:0]   vm_id,
  input  logic [CNT_W-1:0]  page_count,
  input  logic [PAGE_W-1:0] start_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PAGE_W-1:0] page_number,
  output logic [STAT_W-1:0] status
);

  // index and used-count widths follow the parameters; the compare widths are fixed
  localparam int VM_IDX_W = (VM_COUNT > 1) ? $clog2(VM_COUNT) : 1;
  localparam int VM_CMP_W = 9;
  localparam int REQ_W    = 12;
  localparam int USED_W   = $clog2(POOL_PAGES + 2 * MAX_REQUEST);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;

  // per-vm pool memories, valid bit means the entry was written since reset
  logic [USED_W-1:0] used_mem  [VM_COUNT];
  logic [PAGE_W-1:0] start_mem [VM_COUNT];
  logic [VM_COUNT-1:0] vld;

  // request latched at transfer
  logic              st_func;
  logic [VM_IDX_W-1:0] st_idx;
  logic              st_vm_ok;
  logic [CNT_W-1:0]  st_cnt;
  logic [PAGE_W-1:0] st_start;

  // registered memory read data
  logic [USED_W-1:0] rd_used;
  logic [PAGE_W-1:0] rd_start;

  // working registers of the allocation
  logic [USED_W-1:0] cur_used;
  logic [PAGE_W-1:0] cur_start;
  logic [PAGE_W-1:0] base;      // unaligned next free page
  logic [PAGE_W-1:0] shreg;     // dividend, shifted out msb first
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  pad;

  // pending result ahead of the output register
  logic [PAGE_W-1:0] res_page;
  logic [STAT_W-1:0] res_status;

  logic              in_xfer;
  logic [VM_CMP_W-1:0] vm_ext;
  logic [VM_IDX_W-1:0] in_idx;
  logic              in_vm_ok;

  logic [USED_W-1:0] eff_used;
  logic [PAGE_W-1:0] eff_start;
  logic [PAGE_W-1:0] next_free;
  logic              cnt_too_big;
  logic              pool_full;

  logic [CNT_W:0]    trial;
  logic              trial_ge;
  logic [CNT_W-1:0]  rem_next;

  logic [USED_W-1:0] used_new;
  logic              mem_we;
  logic [USED_W-1:0] wr_used;
  logic [PAGE_W-1:0] wr_start;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // vm decode, done once at transfer
  assign vm_ext   = VM_CMP_W'(vm_id);
  assign in_idx   = vm_ext[VM_IDX_W-1:0];
  assign in_vm_ok = vm_ext < VM_CMP_W'(VM_COUNT);

  // an entry never written reads as its reset value of zero
  assign eff_used    = vld[st_idx] ? rd_used  : '0;
  assign eff_start   = vld[st_idx] ? rd_start : '0;
  assign next_free   = eff_start + PAGE_W'(eff_used);
  assign cnt_too_big = REQ_W'(st_cnt) > REQ_W'(MAX_REQUEST);
  assign pool_full   = eff_used >= USED_W'(POOL_PAGES);

  // shared remainder unit: one compare and subtract per cycle
  assign trial    = {rem, shreg[PAGE_W-1]};
  assign trial_ge = trial >= {1'b0, st_cnt};
  assign rem_next = trial_ge ? CNT_W'(trial - {1'b0, st_cnt}) : trial[CNT_W-1:0];

  // used count grows by the count plus the alignment padding
  assign used_new = cur_used + USED_W'(st_cnt) + USED_W'(pad);

  // one write port: a set op writes the new pool, a finished allocation its count
  assign mem_we   = (state == S_FIN)
                 || ((state == S_CHECK) && (st_func == FUNC_SET) && st_vm_ok);
  assign wr_used  = (state == S_FIN) ? used_new  : '0;
  assign wr_start = (state == S_FIN) ? cur_start : st_start;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[st_idx]  <= wr_used;
      start_mem[st_idx] <= wr_start;
    end
    if (in_xfer) begin
      rd_used  <= used_mem[in_idx];
      rd_start <= start_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[st_idx] <= 1'b1;
    end
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load on emit, clear once the waiting result is taken
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (st_func == FUNC_SET || st_cnt == '0 || !st_vm_ok || cnt_too_big
              || pool_full) begin
            state <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == '0) begin
            state <= S_PAD;
          end
        end
        S_PAD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st_func  <= func;
      st_idx   <= in_idx;
      st_vm_ok <= in_vm_ok;
      st_cnt   <= page_count;
      st_start <= start_page;
    end

    case (state)
      S_CHECK: begin
        res_page   <= '0;
        cur_used   <= eff_used;
        cur_start  <= eff_start;
        base       <= next_free;
        shreg      <= next_free;
        rem        <= '0;
        step       <= STEP_W'(DIV_STEPS - 1);
        if (st_func == FUNC_SET) begin
          res_status <= STATUS_OK;
        end else if (st_cnt == '0) begin
          res_status <= STATUS_NULL;
        end else if (!st_vm_ok || cnt_too_big || pool_full) begin
          res_status <= STATUS_EXHAUSTED;
        end else begin
          res_status <= STATUS_OK;
        end
      end
      S_DIV: begin
        rem   <= rem_next;
        shreg <= {shreg[PAGE_W-2:0], 1'b0};
        step  <= step - STEP_W'(1);
      end
      S_PAD: begin
        // pad up to the next multiple of the count
        pad <= (rem == '0) ? '0 : (st_cnt - rem);
      end
      S_FIN: begin
        res_page   <= base + PAGE_W'(pad);
        res_status <= STATUS_OK;
      end
      default: begin
      end
    endcase

    if (state == S_EMIT && out_free) begin
      page_number <= res_page;
      status      <= res_status;
    end
  end

  // a transfer always moves the sequencer into the check step
  `ABPA_ASSERT_NEXT(a_xfer_to_check, clk, rst, in_xfer, state == S_CHECK,
    "request transfer did not start the check step")
  // the partial remainder stays below the divisor through the loop
  `ABPA_ASSERT_NOW(a_rem_bound, clk, rst, state == S_DIV, rem < st_cnt,
    "partial remainder reached the divisor")
  // a failed or null request never carries a page number
  `ABPA_ASSERT_NOW(a_fail_zero_page, clk, rst, out_valid && status != STATUS_OK,
    page_number == '0, "non-ok result carries a page number")

endmodule

[tb/abpa_grant_checker.sv]
// request/result checker for the aligned bump page allocator
// depends on abpa_pkg; keeps its own copy of the per-vm pools and predicts each result
module abpa_grant_checker
  import abpa_pkg::*;
#(
  parameter int VM_COUNT    = 16,
  parameter int POOL_PAGES  = 4096,
  parameter int MAX_REQUEST = 1023
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              func,
  input  logic [VM_W-1:0]   vm_id,
  input  logic [CNT_W-1:0]  page_count,
  input  logic [PAGE_W-1:0] start_page,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [PAGE_W-1:0] page_number,
  input  logic [STAT_W-1:0] status,
  output int                mismatch_count,
  output int                pending_results,
  output int                checked_results
);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [STAT_W-1:0] stat;
  } grant_t;

  grant_t            expected_grants[$];
  int unsigned       vm_used[VM_COUNT];
  logic [PAGE_W-1:0] vm_base[VM_COUNT];
  int                errors  = 0;
  int                checked = 0;

  // next grant for one request, updating the pool copy
  function automatic grant_t predict_grant(input logic fn, input logic [VM_W-1:0] vm,
                                           input logic [CNT_W-1:0] cnt,
                                           input logic [PAGE_W-1:0] start);
    grant_t            g;
    logic [PAGE_W-1:0] p;
    logic [PAGE_W-1:0] rem;
    logic [PAGE_W-1:0] pad;
    int unsigned       adv;
    g.page = '0;
    g.stat = STATUS_OK;
    if (fn == FUNC_SET) begin
      if (int'(vm) < VM_COUNT) begin
        vm_base[vm] = start;
        vm_used[vm] = 0;
      end
    end else if (cnt == '0) begin
      g.stat = STATUS_NULL;
    end else if (int'(vm) >= VM_COUNT || int'(cnt) > MAX_REQUEST) begin
      g.stat = STATUS_EXHAUSTED;
    end else if (vm_used[vm] >= POOL_PAGES) begin
      g.stat = STATUS_EXHAUSTED;
    end else begin
      p   = vm_base[vm] + PAGE_W'(vm_used[vm]);
      rem = p % PAGE_W'(cnt);
      adv = cnt;
      if (rem != '0) begin
        pad = PAGE_W'(cnt) - rem;
        p   = p + pad;
        adv = adv + int'(pad);
      end
      vm_used[vm] = vm_used[vm] + adv;
      g.page      = p;
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      expected_grants.delete();
      for (int i = 0; i < VM_COUNT; i++) begin
        vm_used[i] = 0;
        vm_base[i] = '0;
      end
    end else begin
      // result side first, so a result never matches a request taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          $error("result with no request pending: page_number %h status %0d",
                 page_number, status);
          errors++;
        end else begin
          want = expected_grants.pop_front();
          checked++;
          if (page_number !== want.page) begin
            $error("page_number: expected %h, actual %h", want.page, page_number);
            errors++;
          end
          if (status !== want.stat) begin
            $error("status: expected %0d, actual %0d", want.stat, status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_grants.push_back(predict_grant(func, vm_id, page_count, start_page));
    end
    mismatch_count  <= errors;
    pending_results <= expected_grants.size();
    checked_results <= checked;
  end

endmodule

[tb/aligned_bump_page_allocator_unit_tb.sv]
// top of the aligned bump page allocator testbench: clock, reset, requests, verdict
// depends on abpa_pkg, aligned_bump_page_allocator_unit and abpa_grant_checker
module aligned_bump_page_allocator_unit_tb;
  import abpa_pkg::*;

  localparam int VM_COUNT    = 16;
  localparam int POOL_PAGES  = 4096;
  localparam int MAX_REQUEST = 1023;
  localparam int PHASE_ITEMS = 340;
  localparam int DRAIN_WAIT  = 60;   // margin above the allocation latency

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic              func       = FUNC_SET;
  logic [VM_W-1:0]   vm_id      = '0;
  logic [CNT_W-1:0]  page_count = '0;
  logic [PAGE_W-1:0] start_page = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [PAGE_W-1:0] page_number;
  logic [STAT_W-1:0] status;

  int mismatch_count;
  int pending_results;
  int checked_results;

  // idle rates in percent of cycles, changed from phase to phase
  int send_idle_pct = 35;
  int recv_idle_pct = 81;
  int set_requests  = 0;
  int alloc_requests = 0;

  aligned_bump_page_allocator_unit #(
    .VM_COUNT   (VM_COUNT),
    .POOL_PAGES (POOL_PAGES),
    .MAX_REQUEST(MAX_REQUEST)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .vm_id      (vm_id),
    .page_count (page_count),
    .start_page (start_page),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .page_number(page_number),
    .status     (status)
  );

  abpa_grant_checker #(
    .VM_COUNT   (VM_COUNT),
    .POOL_PAGES (POOL_PAGES),
    .MAX_REQUEST(MAX_REQUEST)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .vm_id          (vm_id),
    .page_count     (page_count),
    .start_page     (start_page),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .page_number    (page_number),
    .status         (status),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results),
    .checked_results(checked_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // receiver stalls at random, one decision per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // random 36-bit page number
  function automatic logic [PAGE_W-1:0] any_page();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PAGE_W-1:0];
  endfunction

  // one request transfer; returns at the edge where it was taken, valid still high
  task automatic send_request(input logic fn, input logic [VM_W-1:0] vm,
                              input logic [CNT_W-1:0] cnt, input logic [PAGE_W-1:0] start);
    // sender gaps, decided cycle by cycle
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    vm_id      <= vm;
    page_count <= cnt;
    start_page <= start;
    do @(posedge clk); while (!in_ready);
    if (fn == FUNC_SET)
      set_requests++;
    else
      alloc_requests++;
  endtask

  // allocation; start_page is don't-care there, so it just carries noise
  task automatic alloc(input logic [VM_W-1:0] vm, input logic [CNT_W-1:0] cnt);
    send_request(FUNC_ALLOC, vm, cnt, any_page());
  endtask

  // mostly allocations on a few busy pools so they fill up, with pool resets
  // and null requests mixed in
  task automatic random_request();
    int unsigned       pick;
    int unsigned       shape;
    logic [VM_W-1:0]   vm;
    logic [CNT_W-1:0]  cnt;
    logic [PAGE_W-1:0] start;
    pick = $urandom_range(99);
    vm   = ($urandom_range(99) < 60) ? VM_W'($urandom_range(3)) : VM_W'($urandom_range(15));
    if (pick < 10) begin
      shape = $urandom_range(2);
      if (shape == 0)
        start = any_page();
      else if (shape == 1)
        start = {PAGE_W{1'b1}} - PAGE_W'($urandom_range(4000));  // wraps soon
      else
        start = PAGE_W'($urandom_range(100000));
      send_request(FUNC_SET, vm, CNT_W'($urandom), start);
    end else if (pick < 14) begin
      alloc(vm, '0);
    end else begin
      shape = $urandom_range(99);
      if (shape < 40)
        cnt = CNT_W'($urandom_range(16, 1));
      else if (shape < 70)
        cnt = CNT_W'($urandom_range(MAX_REQUEST, 1));
      else if (shape < 85)
        cnt = CNT_W'(1 << $urandom_range(9));
      else
        cnt = CNT_W'($urandom_range(MAX_REQUEST, 1000));
      alloc(vm, cnt);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero count first, then a fresh pool at page zero
    alloc(4'd0, '0);
    alloc(4'd0, 10'd1);
    alloc(4'd0, 10'd3);                 // needs padding off page 1
    // top of the page space: grant at the last page, then wrap to zero
    send_request(FUNC_SET, 4'd15, 10'd0, {PAGE_W{1'b1}});
    alloc(4'd15, 10'd1);
    alloc(4'd15, 10'd7);
    // fill a pool with maximum requests until it runs out
    send_request(FUNC_SET, 4'd5, 10'h3ff, PAGE_W'(1000));
    for (int i = 0; i < 5; i++)
      alloc(4'd5, 10'd1023);
    alloc(4'd5, 10'd1);                 // exhausted
    alloc(4'd5, '0);                    // zero count wins over exhaustion
    // a set clears the used count again; alternating bit patterns on the start
    send_request(FUNC_SET, 4'd5, 10'h155, 36'h555555555);
    alloc(4'd5, 10'd1000);
    alloc(4'd5, 10'd1000);
    send_request(FUNC_SET, 4'd10, 10'h2aa, 36'haaaaaaaaa);
    alloc(4'd10, 10'd1023);
    alloc(4'd10, 10'd512);
    send_request(FUNC_SET, 4'd15, 10'd0, '0);
    alloc(4'd15, 10'd512);
    alloc(4'd15, 10'd1);

    // random phases with different idling
    for (int i = 0; i < PHASE_ITEMS; i++)
      random_request();
    send_idle_pct = 81;
    recv_idle_pct = 35;
    for (int i = 0; i < PHASE_ITEMS; i++)
      random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++)
      random_request();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d pool resets and %0d allocation requests, %0d results checked",
             set_requests, alloc_requests, checked_results);
    $display("idling: sender-heavy, receiver-heavy and back-to-back phases");
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("timeout waiting for transfers");
    $display("Mismatches found");
    $finish;
  end

endmodule
